FILE: rtl/ufd_pkg.sv
// Shared types and constants of the ultrasonic frame decoder.
package ufd_pkg;

    localparam int OUT_CHANS = 8;

    localparam logic [7:0] SOF_A = 8'h55;
    localparam logic [7:0] SOF_B = 8'h54;
    localparam logic [7:0] EOF_A = 8'hFF;
    localparam logic [7:0] EOF_B = 8'h00;

    // Parser state codes; code 7 is never entered and behaves like hunting.
    localparam logic [2:0] ST_HUNT    = 3'd0;
    localparam logic [2:0] ST_SOF_B   = 3'd1;
    localparam logic [2:0] ST_SENSOR  = 3'd2;
    localparam logic [2:0] ST_PAYLOAD = 3'd3;
    localparam logic [2:0] ST_EOF_A   = 3'd4;
    localparam logic [2:0] ST_EOF_B   = 3'd5;
    localparam logic [2:0] ST_CHECK   = 3'd6;

    typedef logic [7:0] t_byte;

    // One received byte waiting in the input register.
    typedef struct packed {
        logic  valid;
        t_byte data;
    } t_byte_word;

endpackage

FILE: rtl/ufd_in_stage.sv
// Input register that holds one received byte for the parser.
module ufd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ufd_pkg::t_byte      i_rx_byte,
    input  logic                i_take,
    output ufd_pkg::t_byte_word o_word
);

    logic           r_valid;
    ufd_pkg::t_byte r_data;
    logic           n_valid;

    // The register can be refilled in the same cycle the parser takes it.
    assign o_in_ready = !r_valid || i_take;
    assign n_valid    = (i_in_valid && o_in_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_data <= i_rx_byte;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.data  = r_data;

endmodule

FILE: rtl/ufd_parser.sv
// Frame parser with checksum, channel hold registers and the result register.
module ufd_parser #(
    parameter int CHANNELS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ufd_pkg::t_byte_word i_word,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_frame_ok,
    output ufd_pkg::t_byte      o_chan [ufd_pkg::OUT_CHANS]
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_count, n_count;
    ufd_pkg::t_byte   r_xor, n_xor;
    ufd_pkg::t_byte   r_store [CHANNELS];
    ufd_pkg::t_byte   n_store [CHANNELS];
    ufd_pkg::t_byte   r_held  [CHANNELS];
    ufd_pkg::t_byte   n_held  [CHANNELS];
    logic             r_out_valid, n_out_valid;
    logic             r_out_ok, n_out_ok;
    ufd_pkg::t_byte   r_out_chan [ufd_pkg::OUT_CHANS];
    ufd_pkg::t_byte   w_held_out [ufd_pkg::OUT_CHANS];
    ufd_pkg::t_byte   b;
    logic             ok;

    assign o_take = i_word.valid && (!r_out_valid || i_out_ready);
    assign b      = i_word.data;
    assign ok     = (b == r_xor);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_xor       = r_xor;
        n_store     = r_store;
        n_held      = r_held;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_ok    = r_out_ok;
        if (o_take) begin
            case (r_state)
                ufd_pkg::ST_SOF_B: begin
                    n_state = (b == ufd_pkg::SOF_B) ? ufd_pkg::ST_SENSOR : ufd_pkg::ST_HUNT;
                end
                ufd_pkg::ST_SENSOR: begin
                    n_xor   = b;
                    n_count = '0;
                    n_state = ufd_pkg::ST_PAYLOAD;
                end
                ufd_pkg::ST_PAYLOAD: begin
                    for (int j = 0; j < CHANNELS; j++) begin
                        if (r_count == IDX_W'(j)) begin
                            n_store[j] = b;
                        end
                    end
                    n_xor = r_xor ^ b;
                    if (r_count == LAST_IDX) begin
                        n_count = '0;
                        n_state = ufd_pkg::ST_EOF_A;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                ufd_pkg::ST_EOF_A: begin
                    n_state = (b == ufd_pkg::EOF_A) ? ufd_pkg::ST_EOF_B : ufd_pkg::ST_HUNT;
                end
                ufd_pkg::ST_EOF_B: begin
                    n_state = (b == ufd_pkg::EOF_B) ? ufd_pkg::ST_CHECK : ufd_pkg::ST_HUNT;
                end
                ufd_pkg::ST_CHECK: begin
                    if (ok) begin
                        n_held = r_store;
                    end
                    n_out_valid = 1'b1;
                    n_out_ok    = ok;
                    n_state     = ufd_pkg::ST_HUNT;
                end
                default: begin
                    if (b == ufd_pkg::SOF_A) begin
                        for (int j = 0; j < CHANNELS; j++) begin
                            n_store[j] = '0;
                        end
                        n_count = '0;
                        n_xor   = '0;
                        n_state = ufd_pkg::ST_SOF_B;
                    end else begin
                        n_state = ufd_pkg::ST_HUNT;
                    end
                end
            endcase
        end
    end

    // Map the held channels onto the fixed eight output fields.
    for (genvar j = 0; j < ufd_pkg::OUT_CHANS; j++) begin : g_out_map
        if (j < CHANNELS) begin : g_used
            assign w_held_out[j] = n_held[j];
        end else begin : g_unused
            assign w_held_out[j] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ufd_pkg::ST_HUNT;
            r_count     <= '0;
            r_xor       <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < CHANNELS; j++) begin
                r_store[j] <= '0;
                r_held[j]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_out_valid <= n_out_valid;
            r_store     <= n_store;
            r_held      <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ok <= n_out_ok;
        if (o_take && (r_state == ufd_pkg::ST_CHECK)) begin
            r_out_chan <= w_held_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_frame_ok  = r_out_ok;
    assign o_chan      = r_out_chan;

endmodule

FILE: rtl/ultrasonic_frame_decoder_top.sv
// Top level of the ultrasonic frame decoder: input register, parser, result register.
//
//   channel  direction  handshake                fields
//   in       to block   i_in_valid / o_in_ready  i_rx_byte
//   out      from block o_out_valid / i_out_ready o_frame_ok, o_chan0 .. o_chan7
//
// Each accepted byte is registered in the input register and then parsed; a result
// word for a checksum byte is registered in the result register when the parser takes it.
// One byte per cycle is sustained while the result side keeps taking words; the
// single result register sets that figure, since the parser stalls while it is full.
// Reset (i_rst_n low at a clock edge) returns the parser to hunting for 0x55 and
// clears the checksum, the frame buffer and the held channel distances.
// A stalled result word holds its value; input bytes keep flowing into the input
// register until it and the parser are both blocked by the waiting result.
module ultrasonic_frame_decoder_top #(
    parameter int CHANNELS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_frame_ok,
    output logic [7:0] o_chan0,
    output logic [7:0] o_chan1,
    output logic [7:0] o_chan2,
    output logic [7:0] o_chan3,
    output logic [7:0] o_chan4,
    output logic [7:0] o_chan5,
    output logic [7:0] o_chan6,
    output logic [7:0] o_chan7
);

    // The byte waiting in the input register and the parser's take strobe.
    ufd_pkg::t_byte_word w_word;
    logic               w_take;
    ufd_pkg::t_byte     w_chan [ufd_pkg::OUT_CHANS];

    ufd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_take     (w_take),
        .o_word     (w_word)
    );

    // The parser holds the frame state, the running checksum and the last good
    // channel distances, and loads the result register on every checksum byte.
    ufd_parser #(
        .CHANNELS (CHANNELS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (w_word),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_frame_ok  (o_frame_ok),
        .o_chan      (w_chan)
    );

    assign o_chan0 = w_chan[0];
    assign o_chan1 = w_chan[1];
    assign o_chan2 = w_chan[2];
    assign o_chan3 = w_chan[3];
    assign o_chan4 = w_chan[4];
    assign o_chan5 = w_chan[5];
    assign o_chan6 = w_chan[6];
    assign o_chan7 = w_chan[7];

endmodule

FILE: test/ultrasonic_frame_decoder_top_test.sv
// Self-checking testbench of the ultrasonic frame decoder: byte streams in, frames out.
module ultrasonic_frame_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS     = 8;
    localparam int IDX_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTS   = 50;

    // Shapes of byte sequences that the stimulus generator can queue.
    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_SOF,
        FR_BAD_EOF_A,
        FR_BAD_EOF_B,
        FR_NOISE
    } t_frame_kind;

    // One decoded frame as the block reports it.
    typedef struct packed {
        logic                                ok;
        logic [ufd_pkg::OUT_CHANS-1:0][7:0]  chans;
    } t_frame_result;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    ufd_pkg::t_byte i_rx_byte = '0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_frame_ok;
    logic [7:0] o_chan0, o_chan1, o_chan2, o_chan3, o_chan4, o_chan5, o_chan6, o_chan7;
    logic [ufd_pkg::OUT_CHANS-1:0][7:0] seen_chans;

    assign seen_chans = {o_chan7, o_chan6, o_chan5, o_chan4, o_chan3, o_chan2, o_chan1, o_chan0};

    ultrasonic_frame_decoder_top #(
        .CHANNELS(CHANNELS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_frame_ok (o_frame_ok),
        .o_chan0    (o_chan0),
        .o_chan1    (o_chan1),
        .o_chan2    (o_chan2),
        .o_chan3    (o_chan3),
        .o_chan4    (o_chan4),
        .o_chan5    (o_chan5),
        .o_chan6    (o_chan6),
        .o_chan7    (o_chan7)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Words waiting to be offered, and decoded frames waiting to come out.
    ufd_pkg::t_byte tx_bytes[$];
    t_frame_result  expected_frames[$];

    // Idle and stall rates of the current phase, in percent of cycles.
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;

    // Long receiver hold-off: requested by the stimulus, counted down in its own process.
    logic        hold_go   = 1'b0;
    int unsigned hold_left = 0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned queued_bytes   = 0;
    int unsigned queued_results = 0;

    // Parser copy kept by the testbench. It mirrors the block's state after reset.
    logic [2:0]                parse_st  = ufd_pkg::ST_HUNT;
    logic [IDX_W-1:0]          pay_idx   = '0;
    ufd_pkg::t_byte            sum_acc   = '0;
    logic [CHANNELS-1:0][7:0]  frame_buf = '0;
    logic [CHANNELS-1:0][7:0]  held_dist = '0;

    // Advances the parser copy by one accepted word and queues the decoded frame that a
    // checksum word produces. Held distances only move when the checksum matches.
    function automatic void decode_byte(input ufd_pkg::t_byte b);
        t_frame_result res;
        case (parse_st)
            ufd_pkg::ST_SOF_B: begin
                parse_st = (b == ufd_pkg::SOF_B) ? ufd_pkg::ST_SENSOR : ufd_pkg::ST_HUNT;
            end
            ufd_pkg::ST_SENSOR: begin
                sum_acc  = b;
                pay_idx  = '0;
                parse_st = ufd_pkg::ST_PAYLOAD;
            end
            ufd_pkg::ST_PAYLOAD: begin
                frame_buf[pay_idx] = b;
                sum_acc = sum_acc ^ b;
                if (pay_idx == IDX_W'(CHANNELS - 1)) begin
                    pay_idx  = '0;
                    parse_st = ufd_pkg::ST_EOF_A;
                end else begin
                    pay_idx = pay_idx + 1'b1;
                end
            end
            ufd_pkg::ST_EOF_A: begin
                parse_st = (b == ufd_pkg::EOF_A) ? ufd_pkg::ST_EOF_B : ufd_pkg::ST_HUNT;
            end
            ufd_pkg::ST_EOF_B: begin
                parse_st = (b == ufd_pkg::EOF_B) ? ufd_pkg::ST_CHECK : ufd_pkg::ST_HUNT;
            end
            ufd_pkg::ST_CHECK: begin
                res.ok = (b == sum_acc);
                if (res.ok) begin
                    held_dist = frame_buf;
                end
                res.chans = held_dist;
                expected_frames.push_back(res);
                parse_st = ufd_pkg::ST_HUNT;
            end
            default: begin
                // Hunting: only a first start byte opens a frame, and it clears the buffer.
                if (b == ufd_pkg::SOF_A) begin
                    frame_buf = '0;
                    pay_idx   = '0;
                    sum_acc   = '0;
                    parse_st  = ufd_pkg::ST_SOF_B;
                end else begin
                    parse_st = ufd_pkg::ST_HUNT;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < MAX_PRINTS) begin
            $display("ERROR at %0t ns: %s got %0h expected %0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Mostly uniform bytes, with the framing markers mixed in often enough to show up
    // inside payloads and noise.
    function automatic ufd_pkg::t_byte pick_byte();
        case ($urandom_range(15))
            0:       return ufd_pkg::SOF_A;
            1:       return ufd_pkg::SOF_B;
            2:       return ufd_pkg::EOF_A;
            3:       return ufd_pkg::EOF_B;
            default: return ufd_pkg::t_byte'($urandom);
        endcase
    endfunction

    // Queues one frame of the given shape. A broken frame stops right after the bad byte.
    task automatic queue_frame(input t_frame_kind kind, input ufd_pkg::t_byte sensor,
                               input ufd_pkg::t_byte pay[ufd_pkg::OUT_CHANS]);
        ufd_pkg::t_byte sum;
        ufd_pkg::t_byte flip;
        int unsigned    start_size;
        start_size = tx_bytes.size();
        flip = ufd_pkg::t_byte'($urandom_range(1, 255));
        sum  = sensor;
        foreach (pay[i]) begin
            sum = sum ^ pay[i];
        end
        tx_bytes.push_back(ufd_pkg::SOF_A);
        if (kind == FR_BAD_SOF) begin
            tx_bytes.push_back(ufd_pkg::SOF_B ^ flip);
        end else begin
            tx_bytes.push_back(ufd_pkg::SOF_B);
            tx_bytes.push_back(sensor);
            foreach (pay[i]) begin
                tx_bytes.push_back(pay[i]);
            end
            if (kind == FR_BAD_EOF_A) begin
                tx_bytes.push_back(ufd_pkg::EOF_A ^ flip);
            end else begin
                tx_bytes.push_back(ufd_pkg::EOF_A);
                if (kind == FR_BAD_EOF_B) begin
                    tx_bytes.push_back(ufd_pkg::EOF_B ^ flip);
                end else begin
                    tx_bytes.push_back(ufd_pkg::EOF_B);
                    tx_bytes.push_back((kind == FR_BAD_SUM) ? (sum ^ flip) : sum);
                    queued_results++;
                end
            end
        end
        queued_bytes += tx_bytes.size() - start_size;
    endtask

    // Returns once every queued word has been taken and every decoded frame has arrived.
    task automatic wait_drained();
        while (tx_bytes.size() != 0 || i_in_valid || expected_frames.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: offers the next pending word, holding it steady until the block takes it.
    // Each accepted word goes through the parser copy at the edge that accepts it.
    always @(posedge i_clk) begin : drive_words
        logic offering;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_rx_byte  <= '0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_rx_byte);
                offering = 1'b0;
            end
            if (!offering) begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= tx_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result word with the oldest decoded frame.
    always @(posedge i_clk) begin : check_frames
        t_frame_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("result word with no frame pending, frame_ok", o_frame_ok, 0);
                end else begin
                    want = expected_frames.pop_front();
                    if (o_frame_ok !== want.ok) begin
                        report_mismatch("frame_ok", o_frame_ok, want.ok);
                    end
                    for (int i = 0; i < ufd_pkg::OUT_CHANS; i++) begin
                        if (seen_chans[i] !== want.chans[i]) begin
                            report_mismatch($sformatf("chan%0d", i), seen_chans[i], want.chans[i]);
                        end
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // While the hold-off runs the result register stays full, so the parser and then the
    // input register stall and o_in_ready drops with words still on offer.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        ufd_pkg::t_byte pay[ufd_pkg::OUT_CHANS];
        ufd_pkg::t_byte sensor;
        int unsigned    pick;
        int unsigned    noise_len;
        t_frame_kind    kind;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words. A second 0x55 in place of 0x54 drops the parser back to hunting,
        // and that 0x55 does not open a new frame, so the following 0x54 is ignored.
        tx_bytes.push_back(ufd_pkg::SOF_A);
        tx_bytes.push_back(ufd_pkg::SOF_A);
        tx_bytes.push_back(ufd_pkg::SOF_B);
        // A good frame whose payload carries the extremes and every framing marker.
        pay = '{8'h00, 8'hFF, 8'h55, 8'h54, 8'h01, 8'h80, 8'h7F, 8'hFE};
        queue_frame(FR_GOOD, 8'hFF, pay);
        // A frame that fails its checksum must leave the held distances as they were.
        pay = '{8'hAA, 8'h55, 8'h00, 8'hFF, 8'h54, 8'h33, 8'hCC, 8'h0F};
        queue_frame(FR_BAD_SUM, 8'h00, pay);
        wait_drained();

        // Random phases. Each ends with the sender paused until every frame is out.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 68; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            while (queued_bytes < 120 * (phase + 1) || queued_results < 8 * (phase + 1)) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    kind = FR_GOOD;
                end else if (pick < 75) begin
                    kind = FR_BAD_SUM;
                end else if (pick < 80) begin
                    kind = FR_BAD_SOF;
                end else if (pick < 85) begin
                    kind = FR_BAD_EOF_A;
                end else if (pick < 90) begin
                    kind = FR_BAD_EOF_B;
                end else begin
                    kind = FR_NOISE;
                end
                if (kind == FR_NOISE) begin
                    // Line noise between frames; a stray 0x55 in it may open a partial frame.
                    noise_len = $urandom_range(1, 6);
                    repeat (noise_len) tx_bytes.push_back(pick_byte());
                end else begin
                    sensor = pick_byte();
                    foreach (pay[i]) begin
                        pay[i] = pick_byte();
                    end
                    queue_frame(kind, sensor, pay);
                end
            end
            if (phase == 0) begin
                hold_go = 1'b1;
                while (hold_left == 0) @(negedge i_clk);
                hold_go = 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_frames.size() != 0) begin
            report_mismatch("frames never delivered, count", 0, expected_frames.size());
        end
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
